@@ rtl/core/mft_pkg.sv @@
// ---------------------------------------------------------------------------
// mft_pkg: shared types and constants for the Manchester frame transmitter
// Item and result layouts, frame phase codes, segment lengths and helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package mft_pkg;

  // Frame timing constants
  localparam int unsigned SAFE_COPIES       = 3;
  localparam int unsigned START_PULSE_UNITS = 65;
  localparam int unsigned END_HIGH_UNITS    = 6;
  localparam int unsigned HALF_BIT_RESET    = 150;

  localparam int unsigned UNIT_W  = 8;   // holds any start pulse length
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned WCODE_W = 2;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned BIT_W   = 5;
  localparam int unsigned COPY_W  = 2;
  localparam int unsigned QDEPTH  = 2;

  // Segment length in ticks and the tick counter that spans the longest one
  localparam int unsigned DUR_W = UNIT_W + TICK_W;
  localparam int unsigned CNT_W = $clog2(((START_PULSE_UNITS > END_HIGH_UNITS) ?
                                          START_PULSE_UNITS : END_HIGH_UNITS) *
                                         (1 << TICK_W));

  // Reliability mode codes
  localparam logic [MODE_W-1:0] MODE_UNSAFE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAFE   = 2'd1;

  // Width codes
  localparam logic [WCODE_W-1:0] WCODE_BYTE = 2'd0;
  localparam logic [WCODE_W-1:0] WCODE_HALF = 2'd1;

  // Configuration register indexes
  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_HALF = 1'b1;

  // Frame phases, one-hot
  typedef enum logic [9:0] {
    PH_IDLE  = 10'b00_0000_0001,
    PH_BEG_H1 = 10'b00_0000_0010,
    PH_BEG_L1 = 10'b00_0000_0100,
    PH_BEG_H2 = 10'b00_0000_1000,
    PH_BEG_L2 = 10'b00_0001_0000,
    PH_MODE  = 10'b00_0010_0000,
    PH_WIDTH = 10'b00_0100_0000,
    PH_DATA  = 10'b00_1000_0000,
    PH_END_H = 10'b01_0000_0000,
    PH_END_L = 10'b10_0000_0000
  } phase_t;

  // Decoded item between front and back
  typedef struct packed {
    logic               req;
    logic [WORD_W-1:0]  word;
    logic [WCODE_W-1:0] width;
  } item_t;

  // One result, line_level in the lowest bit
  typedef struct packed {
    logic frame_done;
    logic rejected;
    logic busy_res;
    logic line_level;
  } res_t;

  // Configuration write
  typedef struct packed {
    logic              we;
    logic              index;
    logic [TICK_W-1:0] data;
  } cfg_wr_t;

  // Index of the first data bit sent (MSB) for a width code
  function automatic logic [BIT_W-1:0] top_bit(input logic [WCODE_W-1:0] w);
    logic [BIT_W-1:0] r;
    case (w)
      WCODE_BYTE: r = BIT_W'(7);
      WCODE_HALF: r = BIT_W'(15);
      default:    r = BIT_W'(31);
    endcase
    return r;
  endfunction

  // Segment length in half-bit units
  function automatic logic [UNIT_W-1:0] seg_units(input phase_t ph);
    logic [UNIT_W-1:0] r;
    case (ph)
      PH_BEG_H1, PH_BEG_L1, PH_BEG_H2: r = UNIT_W'(START_PULSE_UNITS);
      PH_END_H:                        r = UNIT_W'(END_HIGH_UNITS);
      default:                         r = UNIT_W'(1);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mft_front.sv @@
// ---------------------------------------------------------------------------
// mft_front: input side of the transmitter
// Takes stream items, decodes the send request and trims the word to width.
// ---------------------------------------------------------------------------
`default_nettype none

module mft_front (
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [39:0]          s_tdata,
  input  wire logic                 s_tuser,
  input  wire logic                 q_full,
  output logic                      q_push,
  output mft_pkg::item_t            q_item
);
  import mft_pkg::*;

  logic [WORD_W-1:0]  word;
  logic [WCODE_W-1:0] wcode;

  assign word  = s_tdata[WORD_W-1:0];
  assign wcode = s_tdata[WORD_W +: WCODE_W];

  // Accept whenever the queue has room
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // Decode and keep only the bits that will be sent
  always_comb begin
    q_item.req   = s_tuser;
    q_item.width = wcode;
    case (wcode)
      WCODE_BYTE: q_item.word = {24'd0, word[7:0]};
      WCODE_HALF: q_item.word = {16'd0, word[15:0]};
      default:    q_item.word = word;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/mft_queue.sv @@
// ---------------------------------------------------------------------------
// mft_queue: two-entry queue between front and back
// Lets the input side keep taking items while the output side stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module mft_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mft_pkg::item_t push_item,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output mft_pkg::item_t      head
);
  import mft_pkg::*;

  item_t      slots [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'(QDEPTH));
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

@@ rtl/core/mft_back.sv @@
// ---------------------------------------------------------------------------
// mft_back: frame sequencer and line driver
// Runs one tick per item, holds the config registers, registers each result.
// ---------------------------------------------------------------------------
`default_nettype none

module mft_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mft_pkg::cfg_wr_t cfg,
  input  wire logic             q_empty,
  input  wire mft_pkg::item_t   q_head,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [7:0]            m_tdata
);
  import mft_pkg::*;

  // Configuration
  logic [MODE_W-1:0] tx_mode;
  logic [TICK_W-1:0] half_bit_ticks;

  // Frame state
  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   tick_count, tick_count_next;
  logic [BIT_W-1:0]   bit_index, bit_index_next;
  logic               second_half, second_half_next;
  logic [COPY_W-1:0]  copy_count, copy_count_next;
  logic [WORD_W-1:0]  held_word, held_word_next;
  logic [WCODE_W-1:0] held_width, held_width_next;
  logic [MODE_W-1:0]  held_mode, held_mode_next;

  res_t              res, res_q;
  logic              start;
  logic              cur_bit;
  logic              seg_end;
  logic [DUR_W-1:0]  dur;
  logic [DUR_W-1:0]  tick_inc;
  logic [TICK_W-1:0] h_eff;

  assign h_eff = (half_bit_ticks == '0) ? TICK_W'(1) : half_bit_ticks;
  assign q_pop = !q_empty && (!m_tvalid || m_tready);
  assign start = q_head.req && (phase == PH_IDLE) && (tx_mode inside {MODE_UNSAFE, MODE_SAFE});

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_mode        <= MODE_UNSAFE;
      half_bit_ticks <= TICK_W'(HALF_BIT_RESET);
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_MODE: tx_mode        <= cfg.data[MODE_W-1:0];
        CFG_HALF: half_bit_ticks <= cfg.data;
        default:  ;
      endcase
    end
  end

  // One tick of the sequencer
  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    second_half_next = second_half;
    copy_count_next  = copy_count;
    held_word_next   = held_word;
    held_width_next  = held_width;
    held_mode_next   = held_mode;
    res              = '0;
    cur_bit          = 1'b0;
    seg_end          = 1'b0;
    dur              = '0;
    tick_inc         = '0;

    res.rejected = q_head.req && !start;

    // Latch a new frame; this tick is its first
    if (start) begin
      held_word_next   = q_head.word;
      held_width_next  = q_head.width;
      held_mode_next   = tx_mode;
      copy_count_next  = (tx_mode == MODE_SAFE) ? COPY_W'(SAFE_COPIES - 1) : '0;
      phase_next       = PH_BEG_H1;
      tick_count_next  = '0;
      bit_index_next   = '0;
      second_half_next = 1'b0;
    end

    if (phase_next != PH_IDLE) begin
      res.busy_res = 1'b1;

      // Bit on the line for the coded phases
      case (phase_next)
        PH_MODE:  cur_bit = held_mode_next[bit_index_next[0]];
        PH_WIDTH: cur_bit = held_width_next[bit_index_next[0]];
        default:  cur_bit = held_word_next[bit_index_next];
      endcase

      case (phase_next)
        PH_BEG_H1, PH_BEG_H2, PH_END_H: res.line_level = 1'b1;
        PH_MODE, PH_WIDTH, PH_DATA:     res.line_level = second_half_next ? cur_bit : !cur_bit;
        default:                        res.line_level = 1'b0;
      endcase

      // Segment timing: ticks since the segment began against its current length
      dur             = {{TICK_W{1'b0}}, seg_units(phase_next)} *
                        {{UNIT_W{1'b0}}, h_eff};
      tick_inc        = DUR_W'(tick_count_next) + DUR_W'(1);
      seg_end         = (tick_inc >= dur);
      tick_count_next = seg_end ? '0 : tick_inc[CNT_W-1:0];

      // Segment advance
      if (seg_end) begin
        case (phase_next)
          PH_BEG_H1: phase_next = PH_BEG_L1;
          PH_BEG_L1: phase_next = PH_BEG_H2;
          PH_BEG_H2: phase_next = PH_BEG_L2;
          PH_BEG_L2: begin
            phase_next       = PH_MODE;
            bit_index_next   = BIT_W'(1);
            second_half_next = 1'b0;
          end
          PH_MODE, PH_WIDTH, PH_DATA: begin
            if (!second_half_next) begin
              second_half_next = 1'b1;
            end else begin
              second_half_next = 1'b0;
              if (bit_index_next != '0) begin
                bit_index_next = bit_index_next - BIT_W'(1);
              end else if (phase_next == PH_MODE) begin
                phase_next     = PH_WIDTH;
                bit_index_next = BIT_W'(1);
              end else if (phase_next == PH_WIDTH) begin
                phase_next     = PH_DATA;
                bit_index_next = top_bit(held_width_next);
              end else begin
                phase_next = PH_END_H;
              end
            end
          end
          PH_END_H: phase_next = PH_END_L;
          PH_END_L: begin
            if (copy_count_next != '0) begin
              copy_count_next  = copy_count_next - COPY_W'(1);
              phase_next       = PH_DATA;
              bit_index_next   = top_bit(held_width_next);
              second_half_next = 1'b0;
            end else begin
              phase_next     = PH_IDLE;
              res.frame_done = 1'b1;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // State and control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_count  <= '0;
      bit_index   <= '0;
      second_half <= 1'b0;
      copy_count  <= '0;
      held_word   <= '0;
      held_width  <= '0;
      held_mode   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (q_pop) begin
        phase       <= phase_next;
        tick_count  <= tick_count_next;
        bit_index   <= bit_index_next;
        second_half <= second_half_next;
        copy_count  <= copy_count_next;
        held_word   <= held_word_next;
        held_width  <= held_width_next;
        held_mode   <= held_mode_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (q_pop) res_q <= res;
  end

  assign m_tdata = {4'd0, res_q};

endmodule

`default_nettype wire

@@ rtl/core/manchester_frame_transmitter.sv @@
// ---------------------------------------------------------------------------
// manchester_frame_transmitter: Manchester coded frame sender, top level
// Front decodes items, a two-entry queue decouples it from the sequencer.
// ---------------------------------------------------------------------------
//
//  Channel   Dir   Handshake            Payload
//  s_*       in    s_tvalid / s_tready  tdata: data_word, width_code; tuser: kind
//  m_*       out   m_tvalid / m_tready  tdata: line_level, busy_res, rejected,
//                                       frame_done
//  cfg_*     in    cfg_we               cfg_index, cfg_data
//
//  One item in, one result out; sustained rate one item per clock while m_tready stays high.
//  From input to result, each item passes the queue and then the result register.
//  Reset (rst, synchronous) empties the queue and returns the line to idle.
//  A stalled output fills the queue, then drops s_tready; no item is lost.
// ---------------------------------------------------------------------------
`default_nettype none

module manchester_frame_transmitter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [31:0] data_word, [33:32] width_code
  input  wire logic        s_tuser,   // [0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [0] line_level, [1] busy_res,
                                      // [2] rejected, [3] frame_done
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  import mft_pkg::*;

  item_t   push_item;
  item_t   head;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;
  cfg_wr_t cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  mft_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (push),
    .q_item   (push_item)
  );

  mft_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  mft_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_head   (head),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Checks
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[1])
    else $error("frame end without busy");

  a_idle_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> !m_tdata[0])
    else $error("line high while idle");

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue full and empty");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire
